@@ rtl/core/dls_pkg.sv @@
// Shared types, codes and reset constants of the daylight lighting sequencer.
`default_nettype none

package dls_pkg;

  // Width of lamp compare values and ramp counts
  localparam int unsigned CmpW = 12;

  // Last valid count of each time field before wrap
  localparam logic [5:0] SecLast  = 6'd59;
  localparam logic [5:0] MinLast  = 6'd59;
  localparam logic [4:0] HourLast = 5'd23;

  // Reset values of configuration registers
  localparam logic [4:0]      OnHourRst     = 5'd8;
  localparam logic [4:0]      OffHourRst    = 5'd21;
  localparam logic [5:0]      OffMinuteRst  = 6'd12;
  localparam logic [CmpW-1:0] RampTopRst    = CmpW'(1275);
  localparam logic [CmpW-1:0] DayBaseRst    = CmpW'(1275);
  localparam logic [3:0]      LightGainRst  = 4'd5;
  localparam logic [CmpW-1:0] MoonCmpRst    = CmpW'(1275);

  // Reset values of schedule state
  localparam logic [CmpW-1:0] RampCountRst  = CmpW'(1275);
  localparam logic [CmpW-1:0] CompareRst    = CmpW'(2184);

  // Input transaction kinds
  typedef enum logic [1:0] {
    KIND_SECOND  = 2'd0,
    KIND_CONTROL = 2'd1,
    KIND_LOAD    = 2'd2,
    KIND_UNUSED  = 2'd3
  } dls_kind_e;

  // Schedule modes
  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_SUNRISE = 3'd1,
    MODE_DAY     = 3'd2,
    MODE_SUNSET  = 3'd3,
    MODE_MOON    = 3'd4
  } dls_mode_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ON_HOUR    = 3'd0,
    CFG_OFF_HOUR   = 3'd1,
    CFG_OFF_MINUTE = 3'd2,
    CFG_RAMP_TOP   = 3'd3,
    CFG_DAY_BASE   = 3'd4,
    CFG_LIGHT_GAIN = 3'd5,
    CFG_MOON_CMP   = 3'd6,
    CFG_NONE       = 3'd7
  } dls_cfg_idx_e;

  typedef struct packed {
    logic [4:0]      on_hour;
    logic [4:0]      off_hour;
    logic [5:0]      off_minute;
    logic [CmpW-1:0] ramp_top;
    logic [CmpW-1:0] day_base;
    logic [3:0]      light_gain;
    logic [CmpW-1:0] moon_compare;
  } dls_cfg_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } dls_time_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ambient_light;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } dls_in_t;

  typedef struct packed {
    logic [2:0]      mode;
    logic [CmpW-1:0] main_compare;
    logic            main_enable;
    logic            moon_enable;
    logic [CmpW-1:0] moon_level;
    logic [4:0]      hour_now;
    logic [5:0]      minute_now;
    logic [5:0]      second_now;
  } dls_out_t;

endpackage

`default_nettype wire

@@ rtl/core/dls_cfg_regs.sv @@
// Configuration register file of the daylight lighting sequencer.
`default_nettype none

module dls_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [2:0]                 wr_index_i,
  input  logic [dls_pkg::CmpW-1:0]   wr_data_i,
  output dls_pkg::dls_cfg_t          cfg_o
);

  dls_pkg::dls_cfg_t cfg_q;
  dls_pkg::dls_cfg_t cfg_d;

  // Decode the write index and take the low bits of the data
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        dls_pkg::CFG_ON_HOUR:    cfg_d.on_hour      = wr_data_i[4:0];
        dls_pkg::CFG_OFF_HOUR:   cfg_d.off_hour     = wr_data_i[4:0];
        dls_pkg::CFG_OFF_MINUTE: cfg_d.off_minute   = wr_data_i[5:0];
        dls_pkg::CFG_RAMP_TOP:   cfg_d.ramp_top     = wr_data_i;
        dls_pkg::CFG_DAY_BASE:   cfg_d.day_base     = wr_data_i;
        dls_pkg::CFG_LIGHT_GAIN: cfg_d.light_gain   = wr_data_i[3:0];
        dls_pkg::CFG_MOON_CMP:   cfg_d.moon_compare = wr_data_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_hour      <= dls_pkg::OnHourRst;
      cfg_q.off_hour     <= dls_pkg::OffHourRst;
      cfg_q.off_minute   <= dls_pkg::OffMinuteRst;
      cfg_q.ramp_top     <= dls_pkg::RampTopRst;
      cfg_q.day_base     <= dls_pkg::DayBaseRst;
      cfg_q.light_gain   <= dls_pkg::LightGainRst;
      cfg_q.moon_compare <= dls_pkg::MoonCmpRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/dls_timekeeper.sv @@
// Time-of-day counter: second ticks, 24-hour wrap and time load.
`default_nettype none

module dls_timekeeper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  dls_pkg::dls_in_t   item_i,
  output dls_pkg::dls_time_t time_q_o,
  output dls_pkg::dls_time_t time_d_o
);

  dls_pkg::dls_time_t time_q;
  dls_pkg::dls_time_t time_d;

  // Advance or load the time; counts at or past their limit wrap with carry
  always_comb begin
    time_d = time_q;
    if (step_en_i) begin
      case (item_i.kind)
        dls_pkg::KIND_SECOND: begin
          if (time_q.second >= dls_pkg::SecLast) begin
            time_d.second = '0;
            if (time_q.minute >= dls_pkg::MinLast) begin
              time_d.minute = '0;
              if (time_q.hour >= dls_pkg::HourLast) begin
                time_d.hour = '0;
              end else begin
                time_d.hour = time_q.hour + 5'd1;
              end
            end else begin
              time_d.minute = time_q.minute + 6'd1;
            end
          end else begin
            time_d.second = time_q.second + 6'd1;
          end
        end
        dls_pkg::KIND_LOAD: begin
          time_d.hour   = item_i.load_hour;
          time_d.minute = item_i.load_minute;
          time_d.second = item_i.load_second;
        end
        default: time_d = time_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
    end else begin
      time_q <= time_d;
    end
  end

  assign time_q_o = time_q;
  assign time_d_o = time_d;

  // A load transaction lands its time exactly
  a_load_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && (item_i.kind == dls_pkg::KIND_LOAD) |=>
      (time_q.hour == $past(item_i.load_hour)) &&
      (time_q.minute == $past(item_i.load_minute)) &&
      (time_q.second == $past(item_i.load_second)))
    else $error("time load lost");

endmodule

`default_nettype wire

@@ rtl/core/dls_scheduler.sv @@
// Five-mode lamp schedule: mode, ramp counter and main compare value.
`default_nettype none

module dls_scheduler (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_en_i,
  input  dls_pkg::dls_in_t         item_i,
  input  dls_pkg::dls_cfg_t        cfg_i,
  input  dls_pkg::dls_time_t       time_i,
  output dls_pkg::dls_mode_e       mode_d_o,
  output logic [dls_pkg::CmpW-1:0] compare_d_o
);

  dls_pkg::dls_mode_e       mode_q;
  dls_pkg::dls_mode_e       mode_d;
  logic [dls_pkg::CmpW-1:0] ramp_q;
  logic [dls_pkg::CmpW-1:0] ramp_d;
  logic [dls_pkg::CmpW-1:0] compare_q;
  logic [dls_pkg::CmpW-1:0] compare_d;
  logic [dls_pkg::CmpW-1:0] light_ext;
  logic [dls_pkg::CmpW-1:0] gain_ext;
  logic [dls_pkg::CmpW-1:0] light_sub;

  // Ambient correction; gain times light stays below the compare range
  assign light_ext = {{(dls_pkg::CmpW-8){1'b0}}, item_i.ambient_light};
  assign gain_ext  = {{(dls_pkg::CmpW-4){1'b0}}, cfg_i.light_gain};
  assign light_sub = light_ext * gain_ext;

  // Step the schedule on a control tick
  always_comb begin
    mode_d    = mode_q;
    ramp_d    = ramp_q;
    compare_d = compare_q;
    if (step_en_i && (item_i.kind == dls_pkg::KIND_CONTROL)) begin
      case (mode_q)
        dls_pkg::MODE_SUNRISE: begin
          ramp_d = ramp_q - dls_pkg::CmpW'(1);
          if (ramp_d == '0) begin
            mode_d = dls_pkg::MODE_DAY;
          end
        end
        dls_pkg::MODE_DAY: begin
          compare_d = (cfg_i.day_base > light_sub) ? (cfg_i.day_base - light_sub) : '0;
          if ((time_i.hour == cfg_i.off_hour) && (time_i.minute == cfg_i.off_minute)) begin
            mode_d = dls_pkg::MODE_SUNSET;
          end
        end
        dls_pkg::MODE_SUNSET: begin
          ramp_d = ramp_q + dls_pkg::CmpW'(1);
          if (ramp_d == cfg_i.ramp_top) begin
            mode_d = dls_pkg::MODE_MOON;
          end
        end
        dls_pkg::MODE_MOON: begin
          if (time_i.hour == '0) begin
            mode_d = dls_pkg::MODE_OFF;
          end
        end
        default: begin
          mode_d = (time_i.hour >= cfg_i.on_hour) ? dls_pkg::MODE_SUNRISE : dls_pkg::MODE_OFF;
        end
      endcase
      // Ramp modes drive the lamp from the ramp counter
      if ((mode_d == dls_pkg::MODE_SUNRISE) || (mode_d == dls_pkg::MODE_SUNSET)) begin
        compare_d = ramp_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= dls_pkg::MODE_OFF;
      ramp_q    <= dls_pkg::RampCountRst;
      compare_q <= dls_pkg::CompareRst;
    end else begin
      mode_q    <= mode_d;
      ramp_q    <= ramp_d;
      compare_q <= compare_d;
    end
  end

  assign mode_d_o    = mode_d;
  assign compare_d_o = compare_d;

  // During a ramp the lamp compare tracks the ramp counter
  a_ramp_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == dls_pkg::MODE_SUNRISE) || (mode_q == dls_pkg::MODE_SUNSET) |->
      compare_q == ramp_q)
    else $error("compare value off the ramp");

  // Sunrise ends in day when the counter reaches zero
  a_sunrise_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && (item_i.kind == dls_pkg::KIND_CONTROL) &&
      (mode_q == dls_pkg::MODE_SUNRISE) && (ramp_q == dls_pkg::CmpW'(1)) |=>
      mode_q == dls_pkg::MODE_DAY)
    else $error("sunrise did not end in day");

  // Schedule state holds without a control tick
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_en_i && (item_i.kind == dls_pkg::KIND_CONTROL)) |=>
      $stable(mode_q) && $stable(ramp_q) && $stable(compare_q))
    else $error("schedule moved without a control tick");

endmodule

`default_nettype wire

@@ rtl/core/daylight_lighting_sequencer_unit.sv @@
// Top level of the daylight lighting sequencer: input register, step logic, result register.
// A transaction is held in the input register, then stepped into the result register.
// Throughput: one transaction per cycle; the input register and the result register
//   advance together whenever the result register is empty or being taken.
// Reset: time 00:00:00, mode off, ramp count 1275, compare 2184, configuration
//   registers at their defaults; both pipeline registers empty.
`default_nettype none

module daylight_lighting_sequencer_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  dls_pkg::dls_in_t         in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output dls_pkg::dls_out_t        out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [2:0]               cfg_index_i,
  input  logic [dls_pkg::CmpW-1:0] cfg_data_i
);

  logic                     in_valid_q;
  dls_pkg::dls_in_t         in_item_q;
  logic                     out_valid_q;
  dls_pkg::dls_out_t        out_item_q;
  dls_pkg::dls_out_t        out_item_d;
  logic                     advance;
  dls_pkg::dls_cfg_t        cfg;
  dls_pkg::dls_time_t       time_q;
  dls_pkg::dls_time_t       time_d;
  dls_pkg::dls_mode_e       mode_d;
  logic [dls_pkg::CmpW-1:0] compare_d;

  // Move the held transaction into the result register when there is room
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  dls_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  dls_timekeeper u_timekeeper (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_item_q),
    .time_q_o  (time_q),
    .time_d_o  (time_d)
  );

  dls_scheduler u_scheduler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (advance),
    .item_i      (in_item_q),
    .cfg_i       (cfg),
    .time_i      (time_q),
    .mode_d_o    (mode_d),
    .compare_d_o (compare_d)
  );

  // Assemble the result from the state after this transaction
  always_comb begin
    out_item_d.mode         = mode_d;
    out_item_d.main_compare = compare_d;
    out_item_d.main_enable  = (mode_d == dls_pkg::MODE_SUNRISE) ||
                              (mode_d == dls_pkg::MODE_DAY) ||
                              (mode_d == dls_pkg::MODE_SUNSET);
    out_item_d.moon_enable  = (mode_d == dls_pkg::MODE_MOON);
    out_item_d.moon_level   = (mode_d == dls_pkg::MODE_MOON) ? cfg.moon_compare : '0;
    out_item_d.hour_now     = time_d.hour;
    out_item_d.minute_now   = time_d.minute;
    out_item_d.second_now   = time_d.second;
  end

  // Valid flags of both pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A held transaction stays held while the result is stalled
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("held transaction dropped");

  // A stepped transaction always yields a pending result
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result missing after step");

endmodule

`default_nettype wire
